@@ rtl/sss_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted set store package
// Shared constants, request/response types and cell control types.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ENTRY_W  = 7;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_MEMBER = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               rejected;
    logic [ENTRY_W-1:0] entry_count;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } cell_op_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic             cmp_en;
    cell_op_e         op;
    logic [VAL_W-1:0] key;
  } cell_ctrl_t;

  // Per-cell compare result, registered inside the cell.
  typedef struct packed {
    logic ge; // slot is empty or holds a value >= key
    logic eq; // slot is valid and holds exactly the key
  } cell_flag_t;

endpackage

@@ rtl/sss_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted set store cell
// Holds one slot, compares it against the broadcast key and shifts
// up or down with its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module sss_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sss_pkg::cell_ctrl_t      ctrl_i,
  input  logic                     prev_ge_i,
  input  logic [sss_pkg::VAL_W-1:0] prev_value_i,
  input  logic                     prev_valid_i,
  input  logic [sss_pkg::VAL_W-1:0] next_value_i,
  input  logic                     next_valid_i,
  output logic [sss_pkg::VAL_W-1:0] value_o,
  output logic                     valid_o,
  output sss_pkg::cell_flag_t      flag_o
);

  logic [sss_pkg::VAL_W-1:0] value_q, value_d;
  logic                      valid_q, valid_d;
  sss_pkg::cell_flag_t       flag_q, flag_d;

  always_comb begin
    flag_d    = flag_q;
    if (ctrl_i.cmp_en) begin
      flag_d.ge = !valid_q || (value_q >= ctrl_i.key);
      flag_d.eq = valid_q && (value_q == ctrl_i.key);
    end
  end

  // The ge flags form a run of zeros then ones along the chain, so the
  // first cell with ge set is the insertion or deletion point.
  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      sss_pkg::OP_INSERT: begin
        if (prev_ge_i) begin
          value_d = prev_value_i;
          valid_d = prev_valid_i;
        end else if (flag_q.ge) begin
          value_d = ctrl_i.key;
          valid_d = 1'b1;
        end
      end
      sss_pkg::OP_DELETE: begin
        if (flag_q.ge) begin
          value_d = next_value_i;
          valid_d = next_valid_i;
        end
      end
      default: begin
        value_d = value_q;
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    flag_q  <= flag_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;
  assign flag_o  = flag_q;

endmodule

@@ rtl/sorted_set_store.sv @@
// ----------------------------------------------------------------------------
// Sorted set store
// Ascending store of 16-bit values built as a chain of compare/shift cells.
// ----------------------------------------------------------------------------
// A taken request moves the store to its update state, and the result strobe
// is registered at its end. The cells compare the key at the edge that takes
// the request; busy is high for the one cycle they shift, and blocks requests.
// Results cannot be stalled; each appears on rsp_o for one cycle with done_o.
// Reset clears every slot valid flag and the entry count; no clearing pass.
module sorted_set_store (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  sss_pkg::req_t req_i,
  output logic          done_o,
  output sss_pkg::rsp_t rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } state_e;

  state_e                    state_q, state_d;
  logic [sss_pkg::CMD_W-1:0] cmd_q;
  logic [sss_pkg::VAL_W-1:0] key_q;
  logic [sss_pkg::CNT_W-1:0] count_q, count_d;
  logic                      done_q, done_d;
  sss_pkg::rsp_t             rsp_q, rsp_d;

  logic                      accept;
  logic                      full;
  logic                      hit;
  sss_pkg::cell_ctrl_t       ctrl;

  logic [sss_pkg::VAL_W-1:0] cell_value [sss_pkg::CAPACITY];
  logic [sss_pkg::CAPACITY-1:0] cell_valid;
  sss_pkg::cell_flag_t       cell_flag  [sss_pkg::CAPACITY];
  logic [sss_pkg::CAPACITY-1:0] eq_vec;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);
  assign full   = (count_q == sss_pkg::CNT_W'(sss_pkg::CAPACITY));
  assign hit    = |eq_vec;

  always_comb begin
    ctrl.cmp_en = accept;
    ctrl.op     = sss_pkg::OP_HOLD;
    ctrl.key    = accept ? req_i.value : key_q;
    if (state_q == ST_UPD) begin
      if (cmd_q == sss_pkg::CMD_INSERT && !full) begin
        ctrl.op = sss_pkg::OP_INSERT;
      end else if (cmd_q == sss_pkg::CMD_DELETE && hit) begin
        ctrl.op = sss_pkg::OP_DELETE;
      end
    end
  end

  for (genvar i = 0; i < sss_pkg::CAPACITY; i++) begin : g_cell
    logic                      prev_ge;
    logic [sss_pkg::VAL_W-1:0] prev_value;
    logic                      prev_valid;
    logic [sss_pkg::VAL_W-1:0] next_value;
    logic                      next_valid;

    if (i == 0) begin : g_first
      assign prev_ge    = 1'b0;
      assign prev_value = '0;
      assign prev_valid = 1'b0;
    end else begin : g_mid_prev
      assign prev_ge    = cell_flag[i-1].ge;
      assign prev_value = cell_value[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == sss_pkg::CAPACITY - 1) begin : g_last
      assign next_value = '0;
      assign next_valid = 1'b0;
    end else begin : g_mid_next
      assign next_value = cell_value[i+1];
      assign next_valid = cell_valid[i+1];
    end

    sss_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_ge_i    (prev_ge),
      .prev_value_i (prev_value),
      .prev_valid_i (prev_valid),
      .next_value_i (next_value),
      .next_valid_i (next_valid),
      .value_o      (cell_value[i]),
      .valid_o      (cell_valid[i]),
      .flag_o       (cell_flag[i])
    );

    assign eq_vec[i] = cell_flag[i].eq;
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (ctrl.op == sss_pkg::OP_INSERT) begin
          count_d = count_q + 1'b1;
        end else if (ctrl.op == sss_pkg::OP_DELETE) begin
          count_d = count_q - 1'b1;
        end
        rsp_d.hit         = hit && (cmd_q == sss_pkg::CMD_DELETE ||
                                    cmd_q == sss_pkg::CMD_MEMBER);
        rsp_d.rejected    = (cmd_q == sss_pkg::CMD_INSERT) && full;
        rsp_d.entry_count = sss_pkg::ENTRY_W'(count_d);
        done_d            = 1'b1;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (accept) begin
      cmd_q <= req_i.command;
      key_q <= req_i.value;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

@@ rtl/sss_checker.sv @@
// ----------------------------------------------------------------------------
// Sorted set store checker
// Port-level checks on request/result timing and result consistency.
// ----------------------------------------------------------------------------
module sss_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input sss_pkg::req_t req_i,
  input logic          done_o,
  input sss_pkg::rsp_t rsp_o
);

  // A taken request raises busy in the cycle after it, blocking the next one.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after a request");

  // Every taken request yields a result strobe.
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> ##1 done_o)
    else $error("result strobe missing after a request");

  // No result strobe without a request taken before it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result strobe without a request");

  // A rejected insert only happens on a full store and never reports a hit.
  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.rejected |->
      !rsp_o.hit &&
      rsp_o.entry_count == sss_pkg::ENTRY_W'(sss_pkg::CAPACITY))
    else $error("rejected result with inconsistent fields");

  // The count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.entry_count <= sss_pkg::ENTRY_W'(sss_pkg::CAPACITY))
    else $error("entry count above capacity");

endmodule

bind sorted_set_store sss_checker u_sss_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Sorted set store testbench
// Sends insert, delete, lookup and unused-code requests with random idle gaps.
// A queue model of the store predicts each response, and a monitor checks
// every response against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [sss_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned      CYCLE_LIMIT = 500000;
  localparam int unsigned      RANDOM_ITEMS = 1780;
  localparam int unsigned      TAIL_ITEMS   = 120;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  sss_pkg::req_t  req_i;
  logic           done_o;
  sss_pkg::rsp_t  rsp_o;

  // Model of the store contents, kept in ascending order.
  logic [sss_pkg::VAL_W-1:0] held_vals[$];
  sss_pkg::rsp_t             pending_rsp_q[$];

  int unsigned error_cnt;
  int unsigned sent_cnt;
  int unsigned cycle_cnt;
  int unsigned idle_pct;

  sorted_set_store dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    error_cnt++;
    $display("%0t: mismatch: %s", $realtime, what);
  endtask

  // First slot whose entry is not below v; the entry count if there is none.
  function automatic int first_not_below(logic [sss_pkg::VAL_W-1:0] v);
    for (int i = 0; i < held_vals.size(); i++) begin
      if (held_vals[i] >= v) return i;
    end
    return held_vals.size();
  endfunction

  function automatic sss_pkg::rsp_t apply_request(sss_pkg::req_t r);
    sss_pkg::rsp_t o;
    int            pos;
    o = '0;
    case (r.command)
      sss_pkg::CMD_INSERT: begin
        if (held_vals.size() >= sss_pkg::CAPACITY) begin
          o.rejected = 1'b1;
        end else begin
          pos = first_not_below(r.value);
          held_vals.insert(pos, r.value);
        end
      end
      sss_pkg::CMD_DELETE: begin
        pos = first_not_below(r.value);
        if (pos < held_vals.size() && held_vals[pos] == r.value) begin
          held_vals.delete(pos);
          o.hit = 1'b1;
        end
      end
      sss_pkg::CMD_MEMBER: begin
        pos = first_not_below(r.value);
        o.hit = (pos < held_vals.size() && held_vals[pos] == r.value);
      end
      default: begin
      end
    endcase
    o.entry_count = sss_pkg::ENTRY_W'(held_vals.size());
    return o;
  endfunction

  // Response monitor: done_o and rsp_o are sampled at the edge that ends
  // the strobe cycle.
  always @(posedge clk_i) begin
    sss_pkg::rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        exp_rsp = pending_rsp_q.pop_front();
        if (rsp_o.hit !== exp_rsp.hit) begin
          report_mismatch($sformatf("hit %b, expected %b", rsp_o.hit, exp_rsp.hit));
        end
        if (rsp_o.rejected !== exp_rsp.rejected) begin
          report_mismatch($sformatf("rejected %b, expected %b",
                                    rsp_o.rejected, exp_rsp.rejected));
        end
        if (rsp_o.entry_count !== exp_rsp.entry_count) begin
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    rsp_o.entry_count, exp_rsp.entry_count));
        end
      end
    end
  end

  task automatic maybe_idle();
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      req_i <= sss_pkg::req_t'($urandom);
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // Called right after a rising edge. The request is taken at the first edge
  // that sees busy low; start stays high so the next request can follow.
  task automatic send_request(logic [sss_pkg::CMD_W-1:0] cmd,
                              logic [sss_pkg::VAL_W-1:0] value);
    sss_pkg::req_t r;
    r.command = cmd;
    r.value   = value;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pending_rsp_q.push_back(apply_request(r));
    sent_cnt++;
    maybe_idle();
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [sss_pkg::VAL_W-1:0] pick_value(bit from_store);
    if (from_store && held_vals.size() > 0 && $urandom_range(0, 3) != 0) begin
      return held_vals[$urandom_range(0, held_vals.size() - 1)];
    end
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      2, 3:    return sss_pkg::VAL_W'($urandom_range(0, 31));
      4:       return sss_pkg::VAL_W'(16'hFFFF - $urandom_range(0, 15));
      default: return sss_pkg::VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [sss_pkg::CMD_W-1:0] pick_cmd(int unsigned ins_pct,
                                                         int unsigned del_pct,
                                                         int unsigned mem_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) return sss_pkg::CMD_INSERT;
    if (roll < ins_pct + del_pct) return sss_pkg::CMD_DELETE;
    if (roll < ins_pct + del_pct + mem_pct) return sss_pkg::CMD_MEMBER;
    return CMD_UNUSED;
  endfunction

  task automatic test_directed_edges();
    send_request(sss_pkg::CMD_MEMBER, 16'h0000);
    send_request(sss_pkg::CMD_DELETE, 16'h0005);
    send_request(sss_pkg::CMD_INSERT, 16'h8000);
    send_request(sss_pkg::CMD_INSERT, 16'h0000);
    send_request(sss_pkg::CMD_INSERT, 16'hFFFF);
    send_request(sss_pkg::CMD_INSERT, 16'h8000);
    send_request(sss_pkg::CMD_INSERT, 16'h7FFF);
    send_request(sss_pkg::CMD_MEMBER, 16'hFFFF);
    send_request(sss_pkg::CMD_MEMBER, 16'h8001);
    send_request(sss_pkg::CMD_MEMBER, 16'h0000);
    // A duplicate leaves one copy behind after the first delete.
    send_request(sss_pkg::CMD_DELETE, 16'h8000);
    send_request(sss_pkg::CMD_MEMBER, 16'h8000);
    send_request(sss_pkg::CMD_DELETE, 16'h8000);
    send_request(sss_pkg::CMD_MEMBER, 16'h8000);
    send_request(sss_pkg::CMD_DELETE, 16'h1234);
    send_request(CMD_UNUSED, 16'hFFFF);
    send_request(CMD_UNUSED, 16'h0000);
    send_request(sss_pkg::CMD_INSERT, 16'hAAAA);
    send_request(sss_pkg::CMD_INSERT, 16'h5555);
    send_request(sss_pkg::CMD_DELETE, 16'h0000);
    send_request(sss_pkg::CMD_DELETE, 16'hFFFF);
    send_request(sss_pkg::CMD_MEMBER, 16'h5555);
    send_request(sss_pkg::CMD_MEMBER, 16'hAAAA);
  endtask

  // Fill to capacity, then keep pushing so that inserts meet a full store.
  task automatic test_fill_to_capacity();
    int unsigned extra;
    extra = 0;
    while (!(held_vals.size() == sss_pkg::CAPACITY && extra >= 4)) begin
      if (held_vals.size() == sss_pkg::CAPACITY) extra++;
      send_request(pick_cmd(80, 6, 9), pick_value(1'b1));
    end
    send_request(sss_pkg::CMD_MEMBER, pick_value(1'b1));
  endtask

  task automatic test_drain_to_empty();
    logic [sss_pkg::CMD_W-1:0] cmd;
    while (held_vals.size() > 0) begin
      cmd = pick_cmd(5, 80, 10);
      send_request(cmd, pick_value(cmd == sss_pkg::CMD_DELETE ||
                                   cmd == sss_pkg::CMD_MEMBER));
    end
    send_request(sss_pkg::CMD_DELETE, pick_value(1'b0));
    send_request(sss_pkg::CMD_MEMBER, pick_value(1'b0));
  endtask

  task automatic test_mixed_traffic(int unsigned n);
    repeat (n) send_request(pick_cmd(35, 30, 28), pick_value(1'b1));
  endtask

  task automatic test_random_rounds();
    while (sent_cnt < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 50;
      endcase
      test_fill_to_capacity();
      test_mixed_traffic(40);
      // Let the store go quiet before emptying it.
      wait_for_results();
      test_drain_to_empty();
      test_mixed_traffic(30);
    end
  endtask

  task automatic test_back_to_back_tail();
    idle_pct = 0;
    test_mixed_traffic(TAIL_ITEMS);
  endtask

  initial begin
    error_cnt = 0;
    sent_cnt  = 0;
    cycle_cnt = 0;
    idle_pct  = 30;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    wait_for_results();
    test_random_rounds();
    test_back_to_back_tail();

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sss_pkg.sv
rtl/sss_cell.sv
rtl/sorted_set_store.sv
rtl/sss_checker.sv
dv/tb_top.sv
